FILE: hw/rtl/zcs_pkg.sv
package zcs_pkg;

  // Input kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_EDGE    = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;

  // Result event codes
  localparam logic [1:0] EV_DELAYED = 2'd0;
  localparam logic [1:0] EV_DIRECT  = 2'd1;
  localparam logic [1:0] EV_DROPPED = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DELAY     = 1'd1;

  localparam logic [15:0] CROSSING_TIMEOUT_RST = 16'd40;
  localparam logic [15:0] SWITCH_DELAY_RST     = 16'd5;
  localparam logic [15:0] TICKS_MAX            = 16'hFFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pin_id;
    logic       pin_level;
  } in_t;

  typedef struct packed {
    logic [7:0] out_pin;
    logic       out_level;
    logic [1:0] event_code;
  } out_t;

  // One queued request: level above pin
  typedef struct packed {
    logic       level;
    logic [7:0] pin;
  } ring_entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

endpackage

FILE: hw/rtl/zcs_ring.sv
module zcs_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  zcs_pkg::ring_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_addr,
  output zcs_pkg::ring_entry_t rd_data
);
  import zcs_pkg::*;

  ring_entry_t mem [DEPTH];
  ring_entry_t rd_data_r;

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/zero_cross_switch_scheduler.sv
// Channel  | Ports                                   | Direction | Handshake
// ---------+-----------------------------------------+-----------+---------------------------
// input    | start, busy, in_data                    | in        | start & !busy
// result   | out_valid, out_data                     | out       | one-cycle strobe
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in      | cfg_valid & cfg_ready
//
// A request, a tick or an idle edge leaves busy low; an edge that pops a queued
// request raises busy in ST_POP, since the ring's read port is registered.
// A result appears on out_data with out_valid in the cycle after its item is taken.
// Reset is synchronous on rst_n; the ring contents are not cleared and need no pass.
// The receiver cannot stall: each result stands for exactly one cycle.
module zero_cross_switch_scheduler #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  zcs_pkg::in_t                     in_data,
  output logic                             out_valid,
  output zcs_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [zcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import zcs_pkg::*;

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  state_t      state_r, state_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt, wr_idx_r, wr_idx_nxt;
  logic [IW-1:0] rd_idx_inc, wr_idx_inc;
  ring_entry_t pending_r;
  logic        running_r, running_nxt;
  logic [15:0] ticks_r, ticks_nxt, ticks_inc;
  logic [15:0] wd_r, wd_nxt;
  logic        failed_r, failed_nxt;
  logic [15:0] timeout_r, delay_r;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic        accept;
  logic        ring_full, ring_empty;
  logic        mem_wr, mem_rd;
  ring_entry_t mem_wdata, mem_rdata;

  assign accept     = start && !busy;
  assign rd_idx_inc = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + IW'(1);
  assign wr_idx_inc = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + IW'(1);
  assign ring_full  = (wr_idx_inc == rd_idx_r);
  assign ring_empty = (wr_idx_r == rd_idx_r);
  assign ticks_inc  = (ticks_r != TICKS_MAX) ? ticks_r + 16'd1 : ticks_r;
  assign mem_wdata  = '{level: in_data.pin_level, pin: in_data.pin_id};

  zcs_ring #(
    .DEPTH (RING_DEPTH),
    .IW    (IW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (wr_idx_r),
    .wr_data (mem_wdata),
    .rd_en   (mem_rd),
    .rd_addr (rd_idx_r),
    .rd_data (mem_rdata)
  );

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= CROSSING_TIMEOUT_RST;
      delay_r   <= SWITCH_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CROSSING_TIMEOUT: timeout_r <= cfg_data;
        CFG_SWITCH_DELAY:     delay_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Process one accepted request
  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    running_nxt   = running_r;
    ticks_nxt     = ticks_r;
    wd_nxt        = wd_r;
    failed_nxt    = failed_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    if (accept) begin
      case (in_data.kind)
        KIND_REQUEST: begin
          if (failed_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{out_pin: in_data.pin_id, out_level: in_data.pin_level,
                              event_code: EV_DIRECT};
          end else if (ring_full) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{out_pin: in_data.pin_id, out_level: in_data.pin_level,
                              event_code: EV_DROPPED};
          end else begin
            mem_wr     = 1'b1;
            wr_idx_nxt = wr_idx_inc;
          end
        end
        KIND_EDGE: begin
          wd_nxt     = '0;
          failed_nxt = 1'b0;
          if (!running_r && !ring_empty) begin
            mem_rd      = 1'b1;
            rd_idx_nxt  = rd_idx_inc;
            running_nxt = 1'b1;
            ticks_nxt   = '0;
          end
        end
        KIND_TICK: begin
          // Watchdog first, then the switch delay
          if (!failed_r) begin
            if (wd_r < timeout_r) begin
              wd_nxt = wd_r + 16'd1;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          if (running_r) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc >= delay_r) begin
              running_nxt   = 1'b0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{out_pin: pending_r.pin, out_level: pending_r.level,
                                event_code: EV_DELAYED};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Pop sequencer: hold off requests while the ring read is in flight
  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (mem_rd) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        busy      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      running_r   <= 1'b0;
      ticks_r     <= '0;
      wd_r        <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      running_r   <= running_nxt;
      ticks_r     <= ticks_nxt;
      wd_r        <= wd_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the popped entry and the result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (state_r == ST_POP) begin
      pending_r <= mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The pop wait follows only an accepted edge that started a delay
  property p_pop_after_edge;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_POP) |-> ($past(accept && in_data.kind == KIND_EDGE) && running_r);
  endproperty
  a_pop_after_edge: assert property (p_pop_after_edge)
    else $error("pop wait without an edge that started a delay");

  // A full ring never takes another entry
  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n)
      (accept && in_data.kind == KIND_REQUEST && ring_full) |=> $stable(wr_idx_r);
  endproperty
  a_no_overflow: assert property (p_no_overflow)
    else $error("write index advanced on a full ring");

  // Every result stems from an item taken the cycle before
  property p_result_from_item;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r |-> $past(accept);
  endproperty
  a_result_from_item: assert property (p_result_from_item)
    else $error("result without an accepted item");

  // A delayed drive ends the running delay
  property p_delay_ends;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.event_code == EV_DELAYED) |-> (!running_r && $past(running_r));
  endproperty
  a_delay_ends: assert property (p_delay_ends)
    else $error("delayed drive while delay still running");

endmodule

FILE: tb/zero_cross_switch_scheduler_tb.sv
`timescale 1ns / 1ps

module zero_cross_switch_scheduler_tb;
  import zcs_pkg::*;

  localparam int unsigned RING_DEPTH  = 16;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  // Tracks queued pin switches, the zero-cross delay and the watchdog,
  // and holds the switch events still due from the block.
  class switch_event_tracker;
    ring_entry_t slots [RING_DEPTH];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    ring_entry_t pending;
    bit          delay_on;
    logic [15:0] ticks_seen;
    logic [15:0] watchdog;
    bit          failed;
    logic [15:0] timeout_ticks;
    logic [15:0] delay_ticks;
    out_t        due_events [$];
    int unsigned mismatches;

    function new();
      rd_ptr        = 0;
      wr_ptr        = 0;
      pending       = '0;
      delay_on      = 1'b0;
      ticks_seen    = '0;
      watchdog      = '0;
      failed        = 1'b0;
      timeout_ticks = CROSSING_TIMEOUT_RST;
      delay_ticks   = SWITCH_DELAY_RST;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      if (idx == CFG_CROSSING_TIMEOUT) begin
        timeout_ticks = value;
      end else if (idx == CFG_SWITCH_DELAY) begin
        delay_ticks = value;
      end
    endfunction

    function void push_event(logic [7:0] pin, logic level, logic [1:0] code);
      out_t ev;
      ev.out_pin    = pin;
      ev.out_level  = level;
      ev.event_code = code;
      due_events.push_back(ev);
    endfunction

    // Advance the state by one accepted request and queue any event it causes
    function void note_item(in_t item);
      int unsigned nxt;
      case (item.kind)
        KIND_REQUEST: begin
          nxt = (wr_ptr + 1) % RING_DEPTH;
          if (failed) begin
            push_event(item.pin_id, item.pin_level, EV_DIRECT);
          end else if (nxt == rd_ptr) begin
            push_event(item.pin_id, item.pin_level, EV_DROPPED);
          end else begin
            slots[wr_ptr].pin   = item.pin_id;
            slots[wr_ptr].level = item.pin_level;
            wr_ptr = nxt;
          end
        end
        KIND_EDGE: begin
          watchdog = '0;
          failed   = 1'b0;
          if (!delay_on && rd_ptr != wr_ptr) begin
            pending    = slots[rd_ptr];
            rd_ptr     = (rd_ptr + 1) % RING_DEPTH;
            delay_on   = 1'b1;
            ticks_seen = '0;
          end
        end
        KIND_TICK: begin
          // watchdog first, then the switch delay
          if (!failed) begin
            if (watchdog < timeout_ticks) begin
              watchdog = watchdog + 16'd1;
            end else begin
              failed = 1'b1;
            end
          end
          if (delay_on) begin
            if (ticks_seen != TICKS_MAX) begin
              ticks_seen = ticks_seen + 16'd1;
            end
            if (ticks_seen >= delay_ticks) begin
              delay_on = 1'b0;
              push_event(pending.pin, pending.level, EV_DELAYED);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one result against the oldest due event
    function void check_event(out_t got);
      out_t want;
      if (due_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: unexpected result pin=%0h level=%0b code=%0d",
                   got.out_pin, got.out_level, got.event_code);
        end
      end else begin
        want = due_events.pop_front();
        if (got.out_pin !== want.out_pin || got.out_level !== want.out_level ||
            got.event_code !== want.event_code) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected pin=%0h level=%0b code=%0d, got pin=%0h level=%0b code=%0d",
                     want.out_pin, want.out_level, want.event_code,
                     got.out_pin, got.out_level, got.event_code);
          end
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               in_data = '0;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  switch_event_tracker tracker = new();
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  zero_cross_switch_scheduler #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check results first, then apply register writes and accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        tracker.check_event(out_data);
      end
      if (cfg_valid && cfg_ready) begin
        tracker.write_reg(cfg_index, cfg_data);
      end
      if (start && !busy) begin
        tracker.note_item(in_data);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one request, with an optional idle burst ahead of it
  task automatic send_item(input logic [1:0] kind, input logic [7:0] pin, input logic level);
    in_t item;
    item.kind      = kind;
    item.pin_id    = pin;
    item.pin_level = level;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind != KIND_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic send_random_request();
    send_item(KIND_REQUEST, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Hold off new requests until every due event has come out
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers, keeping valid high across the pair
  task automatic load_settings(input logic [15:0] timeout_val, input logic [15:0] delay_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CROSSING_TIMEOUT;
    cfg_data  <= timeout_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_SWITCH_DELAY;
    cfg_data  <= delay_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Emulate mains half cycles: an edge, then ticks with switch requests mixed in;
  // some edges go missing so the watchdog trips
  task automatic run_mains(input int unsigned stop_at, input int unsigned req_pct,
                           input int unsigned miss_pct);
    int unsigned span;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) >= miss_pct) begin
        send_item(KIND_EDGE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      span = $urandom_range(1, 12);
      repeat (span) begin
        while ($urandom_range(99) < req_pct) begin
          send_random_request();
        end
        send_item(KIND_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        if ($urandom_range(99) < 2) begin
          send_item(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    logic [15:0] timeout_set [8];
    logic [15:0] delay_set [8];
    int unsigned idle_choices [3];
    int unsigned req_choices [3];
    int unsigned miss_choices [3];
    int unsigned phase;
    logic [15:0] timeout_val;
    logic [15:0] delay_val;

    timeout_set  = '{16'd1, 16'hFFFF, 16'd3, 16'd40, 16'd12, 16'd0, 16'd2, 16'hFFFF};
    delay_set    = '{16'd1, 16'hFFFF, 16'd2, 16'd5, 16'd9, 16'd0, 16'd12, 16'd1};
    idle_choices = '{0, 25, 60};
    req_choices  = '{10, 30, 60};
    miss_choices = '{0, 10, 50};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: queue, pop, edge during a delay, drive after five ticks
    idle_pct = 30;
    send_item(KIND_REQUEST, 8'h00, 1'b0);
    send_item(KIND_REQUEST, 8'hFF, 1'b1);
    send_item(KIND_UNUSED, 8'hAA, 1'b1);
    send_item(KIND_EDGE, 8'h00, 1'b0);
    send_item(KIND_EDGE, 8'h00, 1'b0);
    repeat (5) send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_EDGE, 8'h00, 1'b0);
    settle();

    // Zero registers: fail on the first tick, drive at once, then fill the ring
    load_settings(16'd0, 16'd0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_REQUEST, 8'h5A, 1'b1);
    send_item(KIND_EDGE, 8'h00, 1'b0);
    for (int i = 0; i < RING_DEPTH; i++) begin
      send_item(KIND_REQUEST, 8'(i * 17), 1'(i));
    end
    settle();

    // Random phases, each under its own register settings
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 8) begin
        timeout_val = timeout_set[phase];
        delay_val   = delay_set[phase];
      end else begin
        timeout_val = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 20));
        delay_val   = 16'($urandom_range(0, 10));
      end
      load_settings(timeout_val, delay_val);
      idle_pct = (items_sent + 250 > ITEM_TARGET) ? 0 : idle_choices[$urandom_range(2)];
      run_mains(items_sent + $urandom_range(80, 160), req_choices[$urandom_range(2)],
                miss_choices[$urandom_range(2)]);
      settle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
